// ===== design/acpm_pkg.sv =====
// ----------------------------------------------------------------------------
// acpm_pkg
// shared types, codes and helpers of the path matcher
// ----------------------------------------------------------------------------
package acpm_pkg;

    // input operation codes
    localparam logic [1:0] C_OP_WRITE   = 2'd0;
    localparam logic [1:0] C_OP_SEGMENT = 2'd1;
    localparam logic [1:0] C_OP_CLEAR   = 2'd2;

    // match kinds
    localparam logic [1:0] C_KIND_EQUAL    = 2'd0;
    localparam logic [1:0] C_KIND_STARTS   = 2'd1;
    localparam logic [1:0] C_KIND_ENDS     = 2'd2;
    localparam logic [1:0] C_KIND_CONTAINS = 2'd3;

    // longest path, longer path lengths are folded onto it
    localparam logic [6:0] C_MAX_PATH = 7'd64;

    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_SEGMENT,
        CMD_CLEAR
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [7:0]  node_index;
        logic [31:0] segment_value;
        logic [7:0]  parent_index;
        logic [6:0]  node_depth;
        logic [7:0]  failure_index;
        logic        has_signature;
        logic [15:0] signature_id;
        logic [1:0]  match_kind;
        logic        has_children;
        logic [6:0]  path_length;
    } t_cmd;

    // does a signature of this kind fit where it ends in the path
    function automatic logic kind_fits(input logic [6:0] len, input logic [6:0] idx,
                                       input logic [6:0] layer, input logic [1:0] kind);
        logic [7:0] idx1;
        logic       fit;
        idx1 = {1'b0, idx} + 8'd1;
        fit  = (kind == C_KIND_CONTAINS);
        if (idx1 == {1'b0, layer}) begin
            if (layer == len && kind == C_KIND_EQUAL) fit = 1'b1;
            if (layer < len && kind == C_KIND_STARTS) fit = 1'b1;
        end else if (idx1 > {1'b0, layer}) begin
            if (layer < len && kind == C_KIND_ENDS) fit = 1'b1;
        end
        return fit;
    endfunction

endpackage

// ===== design/acpm_ram.sv =====
// ----------------------------------------------------------------------------
// acpm_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module acpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/acpm_queue.sv =====
// ----------------------------------------------------------------------------
// acpm_queue
// two-entry command queue between front and back
// ----------------------------------------------------------------------------
module acpm_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_mem[r_wr_ptr] <= i_data;
                r_wr_ptr        <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
endmodule

// ===== design/acpm_front.sv =====
// ----------------------------------------------------------------------------
// acpm_front
// takes input beats, classifies them and builds queue commands
// ----------------------------------------------------------------------------
module acpm_front #(
    parameter int NODE_COUNT = 256
) (
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic [1:0]    i_op,
    input  logic [7:0]    i_node_index,
    input  logic [31:0]   i_segment_value,
    input  logic [7:0]    i_parent_index,
    input  logic [6:0]    i_node_depth,
    input  logic [7:0]    i_failure_index,
    input  logic          i_has_signature,
    input  logic [15:0]   i_signature_id,
    input  logic [1:0]    i_match_kind,
    input  logic          i_has_children,
    input  logic [6:0]    i_path_length,
    input  logic          i_full,
    output logic          o_push,
    output acpm_pkg::t_cmd o_cmd
);
    logic w_keep;
    logic [6:0] w_len;

    always_comb begin
        w_keep      = 1'b0;
        o_cmd.kind  = acpm_pkg::CMD_SEGMENT;
        unique case (i_op)
            acpm_pkg::C_OP_WRITE: begin
                o_cmd.kind = acpm_pkg::CMD_WRITE;
                w_keep     = (32'(i_node_index) < 32'(NODE_COUNT));
            end
            acpm_pkg::C_OP_SEGMENT: begin
                o_cmd.kind = acpm_pkg::CMD_SEGMENT;
                w_keep     = 1'b1;
            end
            acpm_pkg::C_OP_CLEAR: begin
                o_cmd.kind = acpm_pkg::CMD_CLEAR;
                w_keep     = 1'b1;
            end
            default: w_keep = 1'b0; // unused op, dropped
        endcase

        // length zero counts as one, long paths fold onto the limit
        if (i_path_length == 7'd0) w_len = 7'd1;
        else if (i_path_length > acpm_pkg::C_MAX_PATH) w_len = acpm_pkg::C_MAX_PATH;
        else w_len = i_path_length;

        o_cmd.node_index    = i_node_index;
        o_cmd.segment_value = i_segment_value;
        o_cmd.parent_index  = i_parent_index;
        o_cmd.node_depth    = i_node_depth;
        o_cmd.failure_index = i_failure_index;
        o_cmd.has_signature = i_has_signature;
        o_cmd.signature_id  = i_signature_id;
        o_cmd.match_kind    = i_match_kind;
        o_cmd.has_children  = i_has_children;
        o_cmd.path_length   = w_len;
    end

    assign o_in_stall = i_full;
    assign o_push     = i_in_valid && !i_full && w_keep;
endmodule

// ===== design/acpm_back.sv =====
// ----------------------------------------------------------------------------
// acpm_back
// node table and trie walk engine
// ----------------------------------------------------------------------------
module acpm_back #(
    parameter int NODE_COUNT   = 256,
    parameter int SEGMENT_BITS = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  acpm_pkg::t_cmd i_cmd,
    output logic           o_cmd_pop,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output logic           o_matched,
    output logic [15:0]    o_match_id
);
    localparam int IW  = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int CTW = IW + 1;
    localparam int ES  = (SEGMENT_BITS < 32) ? SEGMENT_BITS : 32;
    localparam int RW  = ES + 43;

    typedef enum logic [2:0] {
        S_IDLE, S_ROOT_CK, S_NODE_RD, S_NODE_CK, S_SCAN_RD, S_SCAN_CK, S_FIN
    } t_state;

    t_state          r_state;
    logic [NODE_COUNT-1:0] r_valid;
    logic [IW-1:0]   r_cur_node;
    logic [6:0]      r_position;
    logic            r_decided;
    logic [IW-1:0]   r_cur;
    logic [CTW-1:0]  r_step;
    logic [CTW-1:0]  r_scan;
    logic [ES-1:0]   r_seg;
    logic [6:0]      r_len;
    logic [7:0]      r_cur_fail;
    logic            r_hit;
    logic [15:0]     r_id;
    logic            r_out_valid;
    logic            r_matched;
    logic [15:0]     r_match_id;

    logic [IW-1:0]   w_raddr;
    logic [RW-1:0]   w_rdata;
    logic [RW-1:0]   w_wdata;
    logic            w_we;

    logic            d_child;
    logic [1:0]      d_kind;
    logic            d_sig;
    logic [15:0]     d_id;
    logic [7:0]      d_fail;
    logic [6:0]      d_depth;
    logic [7:0]      d_parent;
    logic [ES-1:0]   d_edge;

    logic            w_v_cur;
    logic            w_v_scan;
    logic            w_v_sel;
    logic            w_leaf;
    logic [IW-1:0]   w_fail_rd;
    logic [IW-1:0]   w_fail_saved;
    logic            w_end;
    logic            w_need_out;
    logic            w_can_load;
    logic            w_load;
    logic            w_child_hit;

    assign {d_edge, d_parent, d_depth, d_fail, d_id, d_sig, d_kind, d_child} = w_rdata;

    assign w_we      = o_cmd_pop && (i_cmd.kind == acpm_pkg::CMD_WRITE);
    assign w_wdata   = {i_cmd.segment_value[ES-1:0], i_cmd.parent_index, i_cmd.node_depth,
                        i_cmd.failure_index, i_cmd.signature_id, i_cmd.has_signature,
                        i_cmd.match_kind, i_cmd.has_children};
    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid;

    always_comb begin
        unique case (r_state)
            S_IDLE:    w_raddr = '0;
            S_SCAN_RD: w_raddr = r_scan[IW-1:0];
            default:   w_raddr = r_cur;
        endcase
    end

    acpm_ram #(
        .WIDTH(RW),
        .DEPTH(NODE_COUNT)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(IW'(i_cmd.node_index)),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign w_v_cur  = r_valid[r_cur];
    assign w_v_scan = r_valid[r_scan[IW-1:0]];
    assign w_v_sel  = (r_state == S_SCAN_CK) ? w_v_scan : w_v_cur;
    // signature reports only on a valid leaf whose kind fits
    assign w_leaf   = w_v_sel && d_sig && !d_child &&
                      acpm_pkg::kind_fits(r_len, r_position, d_depth, d_kind);
    assign w_fail_rd    = (!w_v_cur || 32'(d_fail) >= 32'(NODE_COUNT)) ? '0 : IW'(d_fail);
    assign w_fail_saved = (32'(r_cur_fail) >= 32'(NODE_COUNT)) ? '0 : IW'(r_cur_fail);
    assign w_child_hit  = w_v_scan && (32'(d_parent) == 32'(r_cur)) && (d_edge == r_seg);
    assign w_end        = ({1'b0, r_position} + 8'd1) >= {1'b0, r_len};
    assign w_need_out   = r_hit || (w_end && !r_decided);
    assign w_can_load   = !r_out_valid || !i_out_stall;
    assign w_load       = (r_state == S_FIN) && w_need_out && w_can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_cur_node  <= '0;
            r_position  <= '0;
            r_decided   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        unique case (i_cmd.kind)
                            acpm_pkg::CMD_WRITE: r_valid[IW'(i_cmd.node_index)] <= 1'b1;
                            acpm_pkg::CMD_CLEAR: begin
                                r_valid    <= '0;
                                r_cur_node <= '0;
                                r_position <= '0;
                                r_decided  <= 1'b0;
                            end
                            acpm_pkg::CMD_SEGMENT: begin
                                r_seg   <= i_cmd.segment_value[ES-1:0];
                                r_len   <= i_cmd.path_length;
                                r_cur   <= r_cur_node;
                                r_hit   <= 1'b0;
                                r_id    <= '0;
                                r_step  <= '0;
                                r_state <= S_ROOT_CK;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_ROOT_CK: begin
                    // root data is on the read port now
                    if (r_decided || !r_valid[0] || !d_child) r_state <= S_FIN;
                    else r_state <= S_NODE_RD;
                end
                S_NODE_RD: begin
                    if (r_step == CTW'(NODE_COUNT)) begin
                        r_cur   <= '0;
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_NODE_CK;
                    end
                end
                S_NODE_CK: begin
                    if (!(w_v_cur && d_child)) begin
                        if (w_leaf) begin
                            r_hit   <= 1'b1;
                            r_id    <= d_id;
                            r_state <= S_FIN;
                        end else begin
                            r_cur <= w_fail_rd;
                            if (w_fail_rd == '0) r_state <= S_FIN;
                            else begin
                                r_step  <= r_step + 1'b1;
                                r_state <= S_NODE_RD;
                            end
                        end
                    end else begin
                        r_cur_fail <= d_fail;
                        r_scan     <= CTW'(1);
                        r_state    <= S_SCAN_RD;
                    end
                end
                S_SCAN_RD: begin
                    if (r_scan == CTW'(NODE_COUNT)) begin
                        // no child on this segment, take the failure link
                        r_cur <= w_fail_saved;
                        if (w_fail_saved == '0) r_state <= S_FIN;
                        else begin
                            r_step  <= r_step + 1'b1;
                            r_state <= S_NODE_RD;
                        end
                    end else begin
                        r_state <= S_SCAN_CK;
                    end
                end
                S_SCAN_CK: begin
                    if (w_child_hit) begin
                        r_cur <= r_scan[IW-1:0];
                        if (w_leaf) begin
                            r_hit <= 1'b1;
                            r_id  <= d_id;
                        end
                        r_state <= S_FIN;
                    end else begin
                        r_scan  <= r_scan + 1'b1;
                        r_state <= S_SCAN_RD;
                    end
                end
                S_FIN: begin
                    if (!w_need_out || w_can_load) begin
                        if (w_need_out) begin
                            r_matched   <= r_hit;
                            r_match_id  <= r_hit ? r_id : 16'd0;
                        end
                        if (w_end) begin
                            r_cur_node <= '0;
                            r_position <= '0;
                            r_decided  <= 1'b0;
                        end else begin
                            r_position <= r_position + 7'd1;
                            r_cur_node <= r_cur;
                            if (r_hit) r_decided <= 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_matched   = r_matched;
    assign o_match_id  = r_match_id;
endmodule

// ===== design/aho_corasick_path_matcher_core.sv =====
// ----------------------------------------------------------------------------
// aho_corasick_path_matcher_core
// multi-pattern path matcher over a trie held in a node table
// ----------------------------------------------------------------------------
// A node write or a table clear is handled by the back end straight from idle.
// A path segment checks the root, then per walk step reads a node and, where
// the node has children, reads table entries in order from 1, up to
// NODE_COUNT-1, to find the child; the node table has a single read port. The
// front accepts beats into a two-entry queue while the back is busy, and a
// finished result waits in an output register.
module aho_corasick_path_matcher_core #(
    parameter int NODE_COUNT   = 256,
    parameter int SEGMENT_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input beats
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_node_index,
    input  logic [31:0] i_segment_value,
    input  logic [7:0]  i_parent_index,
    input  logic [6:0]  i_node_depth,
    input  logic [7:0]  i_failure_index,
    input  logic        i_has_signature,
    input  logic [15:0] i_signature_id,
    input  logic [1:0]  i_match_kind,
    input  logic        i_has_children,
    input  logic [6:0]  i_path_length,
    // result beats
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_matched,
    output logic [15:0] o_match_id
);
    localparam int QW = $bits(acpm_pkg::t_cmd);

    acpm_pkg::t_cmd w_push_cmd;
    acpm_pkg::t_cmd w_pop_cmd;
    logic           w_push;
    logic           w_full;
    logic           w_pop;
    logic           w_q_valid;
    logic [QW-1:0]  w_q_data;

    // front: handshake and classification of each beat
    acpm_front #(
        .NODE_COUNT(NODE_COUNT)
    ) u_front (
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_node_index   (i_node_index),
        .i_segment_value(i_segment_value),
        .i_parent_index (i_parent_index),
        .i_node_depth   (i_node_depth),
        .i_failure_index(i_failure_index),
        .i_has_signature(i_has_signature),
        .i_signature_id (i_signature_id),
        .i_match_kind   (i_match_kind),
        .i_has_children (i_has_children),
        .i_path_length  (i_path_length),
        .i_full         (w_full),
        .o_push         (w_push),
        .o_cmd          (w_push_cmd)
    );

    // decoupling queue
    acpm_queue #(
        .WIDTH(QW)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_data (w_push_cmd),
        .o_full (w_full),
        .i_pop  (w_pop),
        .o_valid(w_q_valid),
        .o_data (w_q_data)
    );

    assign w_pop_cmd = acpm_pkg::t_cmd'(w_q_data);

    // back: node table and walk
    acpm_back #(
        .NODE_COUNT  (NODE_COUNT),
        .SEGMENT_BITS(SEGMENT_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(w_q_valid),
        .i_cmd      (w_pop_cmd),
        .o_cmd_pop  (w_pop),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_matched  (o_matched),
        .o_match_id (o_match_id)
    );
endmodule

// ===== design/acpm_checker.sv =====
// ----------------------------------------------------------------------------
// acpm_checker
// port-level checks on the path matcher
// ----------------------------------------------------------------------------
module acpm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_matched,
    input logic [15:0] o_match_id
);
    // a held result beat keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_matched) &&
        $stable(o_match_id))
        else $error("result beat changed while stalled");

    // no match carries id zero
    a_nomatch_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_matched |-> o_match_id == 16'd0)
        else $error("unmatched result with non-zero id");

    // reset empties the output register
    a_reset_out: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_out_valid)
        else $error("result beat right after reset");
endmodule

bind aho_corasick_path_matcher_core acpm_checker u_acpm_checker (.*);

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the path matcher: builds small tries, walks paths
// through them and checks every result beat against an internal prediction
// ----------------------------------------------------------------------------
module tb_top;

    // op code the block ignores
    localparam logic [1:0] OP_SPARE   = 2'd3;
    localparam int         TABLE_SIZE = 256;
    localparam int         ITEM_GOAL  = 1600;
    localparam longint     CYCLE_CAP  = 60000000;
    localparam int         DRAIN_WAIT = 6000;
    // long receiver hold, starts once this many beats went in
    localparam int         HOLD_AT    = 400;
    localparam int         HOLD_LEN   = 20000;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  node_index;
        logic [31:0] segment_value;
        logic [7:0]  parent_index;
        logic [6:0]  node_depth;
        logic [7:0]  failure_index;
        logic        has_signature;
        logic [15:0] signature_id;
        logic [1:0]  match_kind;
        logic        has_children;
        logic [6:0]  path_length;
    } t_beat;

    typedef struct packed {
        logic        matched;
        logic [15:0] match_id;
    } t_verdict;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // input side
    logic  in_valid = 1'b0;
    t_beat drv      = '0;
    logic  o_in_stall;

    // output side
    logic        out_stall = 1'b0;
    logic        o_out_valid;
    logic        o_matched;
    logic [15:0] o_match_id;

    always #1 i_clk = ~i_clk;

    aho_corasick_path_matcher_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (o_in_stall),
        .i_op            (drv.op),
        .i_node_index    (drv.node_index),
        .i_segment_value (drv.segment_value),
        .i_parent_index  (drv.parent_index),
        .i_node_depth    (drv.node_depth),
        .i_failure_index (drv.failure_index),
        .i_has_signature (drv.has_signature),
        .i_signature_id  (drv.signature_id),
        .i_match_kind    (drv.match_kind),
        .i_has_children  (drv.has_children),
        .i_path_length   (drv.path_length),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (out_stall),
        .o_matched       (o_matched),
        .o_match_id      (o_match_id)
    );

    // ------------------------------------------------------------------
    // trie mirror and walk state
    // ------------------------------------------------------------------
    logic [31:0] edge_tbl   [TABLE_SIZE];
    logic [7:0]  parent_tbl [TABLE_SIZE];
    logic [6:0]  depth_tbl  [TABLE_SIZE];
    logic [7:0]  fail_tbl   [TABLE_SIZE];
    logic [15:0] sig_tbl    [TABLE_SIZE];
    logic [1:0]  kind_tbl   [TABLE_SIZE];
    bit          node_ok    [TABLE_SIZE];
    bit          sig_ok     [TABLE_SIZE];
    bit          kids_ok    [TABLE_SIZE];
    int unsigned walk_node;
    int unsigned walk_pos;
    bit          path_done;

    t_beat    pending_beats[$];
    t_verdict awaited_verdicts[$];
    int       mismatches;
    int       beats_taken;

    task automatic report(input string what);
        mismatches++;
        $display("mismatch: %s", what);
    endtask

    // does a signature of this kind fit at this place in the path
    function automatic bit kind_ok(int unsigned len, int unsigned pos,
                                   int unsigned layer, logic [1:0] kind);
        if (pos + 1 == layer) begin
            if (layer == len && kind == acpm_pkg::C_KIND_EQUAL) return 1'b1;
            if (layer < len && kind == acpm_pkg::C_KIND_STARTS) return 1'b1;
        end else if (pos + 1 > layer) begin
            if (layer < len && kind == acpm_pkg::C_KIND_ENDS) return 1'b1;
        end
        return kind == acpm_pkg::C_KIND_CONTAINS;
    endfunction

    // a signature only counts on a valid leaf
    function automatic bit leaf_hit(int unsigned n, int unsigned len, int unsigned pos);
        if (!node_ok[n] || !sig_ok[n]) return 1'b0;
        if (!kind_ok(len, pos, depth_tbl[n], kind_tbl[n])) return 1'b0;
        return !kids_ok[n];
    endfunction

    function automatic int unsigned fail_target(int unsigned n);
        return node_ok[n] ? fail_tbl[n] : 0;
    endfunction

    // update the mirror for one accepted beat, queue any verdict it causes
    task automatic track_beat(input t_beat b);
        int unsigned len, cur, n, j, nxt;
        bit          adv, hit, found, was_done;
        logic [15:0] id;
        case (b.op)
            acpm_pkg::C_OP_WRITE: begin
                edge_tbl[b.node_index]   = b.segment_value;
                parent_tbl[b.node_index] = b.parent_index;
                depth_tbl[b.node_index]  = b.node_depth;
                fail_tbl[b.node_index]   = b.failure_index;
                sig_tbl[b.node_index]    = b.signature_id;
                kind_tbl[b.node_index]   = b.match_kind;
                node_ok[b.node_index]    = 1'b1;
                sig_ok[b.node_index]     = b.has_signature;
                kids_ok[b.node_index]    = b.has_children;
            end
            acpm_pkg::C_OP_CLEAR: begin
                foreach (node_ok[k]) node_ok[k] = 1'b0;
                walk_node = 0;
                walk_pos  = 0;
                path_done = 1'b0;
            end
            acpm_pkg::C_OP_SEGMENT: begin
                len = b.path_length;
                if (len == 0) len = 1;
                if (len > acpm_pkg::C_MAX_PATH) len = acpm_pkg::C_MAX_PATH;
                cur = walk_node;
                hit = 1'b0;
                id  = '0;
                // no walk without a root that has children
                if (!path_done && node_ok[0] && kids_ok[0]) begin
                    adv = 1'b0;
                    for (n = 0; n < TABLE_SIZE && !adv && !hit; n++) begin
                        if (!(node_ok[cur] && kids_ok[cur])) begin
                            if (leaf_hit(cur, len, walk_pos)) begin
                                hit = 1'b1;
                                id  = sig_tbl[cur];
                            end else begin
                                cur = fail_target(cur);
                                if (cur == 0) adv = 1'b1;
                            end
                        end else begin
                            // lowest matching child index wins
                            found = 1'b0;
                            nxt   = 0;
                            for (j = 1; j < TABLE_SIZE; j++) begin
                                if (!found && node_ok[j] && parent_tbl[j] == cur
                                    && edge_tbl[j] == b.segment_value) begin
                                    found = 1'b1;
                                    nxt   = j;
                                end
                            end
                            if (found) begin
                                cur = nxt;
                                if (leaf_hit(cur, len, walk_pos)) begin
                                    hit = 1'b1;
                                    id  = sig_tbl[cur];
                                end else begin
                                    adv = 1'b1;
                                end
                            end else begin
                                cur = fail_target(cur);
                                if (cur == 0) adv = 1'b1;
                            end
                        end
                    end
                    // failure cycle: give up on this segment
                    if (!adv && !hit) cur = 0;
                end
                was_done = path_done;
                if (hit) begin
                    awaited_verdicts.push_back('{matched: 1'b1, match_id: id});
                    path_done = 1'b1;
                end
                if (walk_pos + 1 >= len) begin
                    if (!hit && !was_done)
                        awaited_verdicts.push_back('{matched: 1'b0, match_id: 16'd0});
                    walk_node = 0;
                    walk_pos  = 0;
                    path_done = 1'b0;
                end else begin
                    walk_pos++;
                    walk_node = cur;
                end
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------
    function automatic t_beat node_beat(int unsigned idx, logic [31:0] val, int unsigned par,
                                        int unsigned dep, int unsigned fl, bit sig,
                                        logic [15:0] id, logic [1:0] kind, bit kids);
        t_beat b;
        b = '0;
        b.op            = acpm_pkg::C_OP_WRITE;
        b.node_index    = 8'(idx);
        b.segment_value = val;
        b.parent_index  = 8'(par);
        b.node_depth    = 7'(dep);
        b.failure_index = 8'(fl);
        b.has_signature = sig;
        b.signature_id  = id;
        b.match_kind    = kind;
        b.has_children  = kids;
        return b;
    endfunction

    function automatic t_beat seg_beat(logic [31:0] val, logic [6:0] len);
        t_beat b;
        b = t_beat'({$urandom, $urandom, $urandom});
        b.op            = acpm_pkg::C_OP_SEGMENT;
        b.segment_value = val;
        b.path_length   = len;
        return b;
    endfunction

    function automatic t_beat clear_beat();
        t_beat b;
        b    = t_beat'({$urandom, $urandom, $urandom});
        b.op = acpm_pkg::C_OP_CLEAR;
        return b;
    endfunction

    logic [31:0] alphabet[4];

    function automatic logic [31:0] pick_symbol();
        return ($urandom_range(0, 99) < 85) ? alphabet[$urandom_range(0, 3)] : $urandom;
    endfunction

    // random trie: parents and failure links always point to earlier nodes
    task automatic build_trie(input int unsigned count);
        int unsigned par[64], dep[64], slot[64], fl;
        bit          kids[64];
        bit          flip;
        flip = ($urandom_range(0, 3) == 0);
        foreach (alphabet[a]) alphabet[a] = $urandom;
        for (int k = 0; k < count; k++) begin
            kids[k] = 1'b0;
            slot[k] = (k == 0) ? 0 : (flip ? TABLE_SIZE - k : k);
        end
        dep[0] = 0;
        for (int k = 1; k < count; k++) begin
            par[k] = $urandom_range(0, k - 1);
            dep[k] = dep[par[k]] + 1;
            kids[par[k]] = 1'b1;
        end
        pending_beats.push_back(clear_beat());
        pending_beats.push_back(node_beat(0, $urandom, 0, 0, 0, 1'($urandom_range(0, 1)),
                                          16'($urandom), 2'($urandom), kids[0]));
        for (int k = 1; k < count; k++) begin
            fl = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, k - 1);
            pending_beats.push_back(node_beat(
                slot[k], alphabet[$urandom_range(0, 3)], slot[par[k]],
                ($urandom_range(0, 9) == 0) ? $urandom_range(0, 64) : dep[k],
                slot[fl], $urandom_range(0, 3) != 0, 16'($urandom), 2'($urandom),
                ($urandom_range(0, 15) == 0) ? !kids[k] : kids[k]));
        end
    endtask

    task automatic add_path(input int unsigned len);
        for (int s = 0; s < len; s++)
            pending_beats.push_back(seg_beat(pick_symbol(), 7'(len)));
    endtask

    task automatic add_directed();
        logic [31:0] sym_a, sym_b, sym_c, sym_d;
        sym_a = 32'h0000_0000;
        sym_b = 32'hFFFF_FFFF;
        sym_c = 32'h1234_5678;
        sym_d = 32'hA5A5_5A5A;
        // root missing, then root without children
        pending_beats.push_back(seg_beat(sym_a, 1));
        pending_beats.push_back(node_beat(0, 0, 0, 0, 0, 0, 0, acpm_pkg::C_KIND_EQUAL, 0));
        pending_beats.push_back(seg_beat(sym_a, 0));
        pending_beats.push_back(node_beat(0, 0, 0, 0, 0, 0, 0, acpm_pkg::C_KIND_EQUAL, 1));
        // equal leaf on a one-segment path
        pending_beats.push_back(node_beat(1, sym_a, 0, 1, 0, 1, 16'hFFFF,
                                          acpm_pkg::C_KIND_EQUAL, 0));
        pending_beats.push_back(seg_beat(sym_a, 1));
        // starts-with on a non-leaf stays silent, contains leaf below it hits
        pending_beats.push_back(node_beat(2, sym_b, 0, 1, 0, 1, 16'd1,
                                          acpm_pkg::C_KIND_STARTS, 1));
        pending_beats.push_back(node_beat(3, sym_c, 2, 2, 1, 1, 16'd2,
                                          acpm_pkg::C_KIND_CONTAINS, 0));
        // segments after the hit are swallowed
        pending_beats.push_back(seg_beat(sym_b, 3));
        pending_beats.push_back(seg_beat(sym_c, 3));
        pending_beats.push_back(seg_beat(sym_d, 3));
        // failure links bouncing between two nodes
        pending_beats.push_back(node_beat(4, sym_d, 0, 1, 5, 0, 0, acpm_pkg::C_KIND_ENDS, 1));
        pending_beats.push_back(node_beat(5, sym_c, 0, 1, 4, 0, 0, acpm_pkg::C_KIND_ENDS, 1));
        pending_beats.push_back(seg_beat(sym_d, 2));
        pending_beats.push_back(seg_beat(sym_a, 2));
        // highest entry with every field at its top, and an overlong path
        pending_beats.push_back(node_beat(255, sym_b, 255, 127, 255, 1, 16'hFFFF,
                                          acpm_pkg::C_KIND_CONTAINS, 1));
        pending_beats.push_back(seg_beat(sym_b, 7'h7F));
        // ignored op, then clear mid-path restarts it
        pending_beats.push_back(t_beat'({OP_SPARE, {90{1'b1}}}));
        pending_beats.push_back(clear_beat());
        pending_beats.push_back(seg_beat(sym_a, 1));
    endtask

    task automatic add_noise();
        t_beat b;
        b = t_beat'({$urandom, $urandom, $urandom});
        case ($urandom_range(0, 3))
            0: b.op = acpm_pkg::C_OP_WRITE;
            1: b.op = acpm_pkg::C_OP_SEGMENT;
            2: b.op = OP_SPARE;
            default: b.op = acpm_pkg::C_OP_CLEAR;
        endcase
        pending_beats.push_back(b);
    endtask

    // ------------------------------------------------------------------
    // input driver
    // ------------------------------------------------------------------
    int unsigned send_gap   = 0;
    bit          send_quiet = 1'b0;

    always @(posedge i_clk) begin
        logic  nv;
        t_beat nb;
        bit    take;
        nv = in_valid;
        nb = drv;
        if (i_rst_n) begin
            take = in_valid && !o_in_stall;
            if (take) begin
                track_beat(drv);
                beats_taken++;
                if (beats_taken % 200 == 0) send_quiet = !send_quiet;
                send_gap = send_quiet ? 0 : $urandom_range(0, 8);
            end
            // a stalled beat stays put
            if (!in_valid || take) begin
                if (send_gap > 0) begin
                    send_gap--;
                    nv = 1'b0;
                end else if (pending_beats.size() > 0) begin
                    nb = pending_beats.pop_front();
                    nv = 1'b1;
                end else begin
                    nv = 1'b0;
                end
            end
        end
        in_valid <= nv;
        drv      <= nb;
    end

    // ------------------------------------------------------------------
    // result monitor and receiver back-pressure
    // ------------------------------------------------------------------
    int unsigned recv_wait  = 0;
    int unsigned hold_count = 0;
    bit          hold_done  = 1'b0;
    bit          recv_quiet = 1'b0;
    int          verdicts_seen = 0;

    // one long hold so the block backs up into its input
    always @(posedge i_clk) begin
        if (!hold_done && beats_taken >= HOLD_AT) begin
            hold_count++;
            if (hold_count >= HOLD_LEN) hold_done = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_verdict exp_v;
        if (i_rst_n && o_out_valid && !out_stall) begin
            verdicts_seen++;
            if (verdicts_seen % 40 == 0) recv_quiet = !recv_quiet;
            if (awaited_verdicts.size() == 0) begin
                report($sformatf("unexpected result matched=%0b id=%0h", o_matched, o_match_id));
            end else begin
                exp_v = awaited_verdicts.pop_front();
                if (o_matched !== exp_v.matched)
                    report($sformatf("matched %0b, wanted %0b", o_matched, exp_v.matched));
                if (o_match_id !== exp_v.match_id)
                    report($sformatf("match_id %0h, wanted %0h", o_match_id, exp_v.match_id));
            end
            recv_wait = recv_quiet ? 0 : $urandom_range(0, 8);
        end else if (recv_wait > 0 && o_out_valid) begin
            recv_wait--;
        end
        out_stall <= (hold_count > 0 && !hold_done) || (recv_wait > 0);
    end

    // ------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------
    longint cycles = 0;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("aho_corasick_path_matcher_core verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        int unsigned paths;
        mismatches  = 0;
        beats_taken = 0;
        walk_node   = 0;
        walk_pos    = 0;
        path_done   = 1'b0;
        foreach (node_ok[k]) node_ok[k] = 1'b0;

        add_directed();
        while (pending_beats.size() < ITEM_GOAL) begin
            build_trie($urandom_range(2, 12));
            paths = $urandom_range(2, 6);
            for (int p = 0; p < paths; p++) begin
                if ($urandom_range(0, 9) == 0) add_noise();
                add_path(($urandom_range(0, 24) == 0) ? 64 : $urandom_range(1, 6));
            end
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_beats.size() > 0 || in_valid) @(posedge i_clk);
        while (awaited_verdicts.size() > 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("aho_corasick_path_matcher_core verification clean");
        end else begin
            $display("aho_corasick_path_matcher_core verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/acpm_pkg.sv
design/acpm_ram.sv
design/acpm_queue.sv
design/acpm_front.sv
design/acpm_back.sv
design/aho_corasick_path_matcher_core.sv
design/acpm_checker.sv
verif/tb_top.sv
